### design/fsc_pkg.sv
// Shared types and constants for the frustum sphere cull core.
// Used by fsc_cell and frustum_sphere_cull_core; depends on nothing else.
package fsc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_W_DEF    = 16;

  // Only the six architected plane registers can be written.
  localparam int PLANE_REGS  = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int FIELD_W  = 16;
  localparam int RADIUS_W = 15;

  // Q8.8 terms are lifted by this shift to line up with Q1.14 * Q8.8 products.
  localparam int FRAC_ALIGN = 14;

  localparam int NX_LSB = 0;
  localparam int NY_LSB = 16;
  localparam int NZ_LSB = 32;
  localparam int D_LSB  = 48;

  // Per-word flags carried down the cell chain.
  typedef struct packed {
    logic last;
    logic vis;
  } cull_tag_t;

endpackage

### design/fsc_cell.sv
// One plane test cell: holds one plane register, multiplies in the first stage
// and accumulates and compares in the second. Depends on fsc_pkg.
module fsc_cell #(
  parameter int COORD_WIDTH = fsc_pkg::COORD_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              plane_we,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]    plane_wdata,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_WIDTH-1:0]     up_cx,
  input  logic signed [COORD_WIDTH-1:0]     up_cy,
  input  logic signed [COORD_WIDTH-1:0]     up_cz,
  input  logic [fsc_pkg::RADIUS_W-1:0]      up_rad,
  input  fsc_pkg::cull_tag_t                up_tag,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [COORD_WIDTH-1:0]     dn_cx,
  output logic signed [COORD_WIDTH-1:0]     dn_cy,
  output logic signed [COORD_WIDTH-1:0]     dn_cz,
  output logic [fsc_pkg::RADIUS_W-1:0]      dn_rad,
  output fsc_pkg::cull_tag_t                dn_tag
);
  import fsc_pkg::*;

  localparam int PROD_W = COORD_WIDTH + FIELD_W;
  localparam int MAX_W  = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int SUM_W  = MAX_W + 18;

  logic [CFG_DATA_W-1:0]     plane_r, plane_nxt;
  logic signed [FIELD_W-1:0] nx, ny, nz, dofs;

  logic                          a_valid_r, a_valid_nxt;
  logic signed [PROD_W-1:0]      a_px_r, a_px_nxt, a_py_r, a_py_nxt, a_pz_r, a_pz_nxt;
  logic signed [COORD_WIDTH-1:0] a_cx_r, a_cx_nxt, a_cy_r, a_cy_nxt, a_cz_r, a_cz_nxt;
  logic [RADIUS_W-1:0]           a_rad_r, a_rad_nxt;
  cull_tag_t                     a_tag_r, a_tag_nxt;

  logic                          b_valid_r, b_valid_nxt;
  logic signed [COORD_WIDTH-1:0] b_cx_r, b_cx_nxt, b_cy_r, b_cy_nxt, b_cz_r, b_cz_nxt;
  logic [RADIUS_W-1:0]           b_rad_r, b_rad_nxt;
  cull_tag_t                     b_tag_r, b_tag_nxt;

  logic                    a_ready, b_ready;
  logic signed [SUM_W-1:0] dist_sum;

  assign nx   = plane_r[NX_LSB +: FIELD_W];
  assign ny   = plane_r[NY_LSB +: FIELD_W];
  assign nz   = plane_r[NZ_LSB +: FIELD_W];
  assign dofs = plane_r[D_LSB  +: FIELD_W];

  assign plane_nxt = plane_we ? plane_wdata : plane_r;

  // Each stage moves when it is empty or its successor takes its word.
  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_px_nxt    = a_px_r;
    a_py_nxt    = a_py_r;
    a_pz_nxt    = a_pz_r;
    a_cx_nxt    = a_cx_r;
    a_cy_nxt    = a_cy_r;
    a_cz_nxt    = a_cz_r;
    a_rad_nxt   = a_rad_r;
    a_tag_nxt   = a_tag_r;
    if (a_ready) begin
      a_valid_nxt = up_valid;
      a_px_nxt    = nx * up_cx;
      a_py_nxt    = ny * up_cy;
      a_pz_nxt    = nz * up_cz;
      a_cx_nxt    = up_cx;
      a_cy_nxt    = up_cy;
      a_cz_nxt    = up_cz;
      a_rad_nxt   = up_rad;
      a_tag_nxt   = up_tag;
    end
  end

  // Distance plus radius; the sphere lies fully outside when this goes negative.
  assign dist_sum = SUM_W'(a_px_r) + SUM_W'(a_py_r) + SUM_W'(a_pz_r)
                  + (SUM_W'(dofs) <<< FRAC_ALIGN)
                  + (SUM_W'($signed({1'b0, a_rad_r})) <<< FRAC_ALIGN);

  always_comb begin
    b_valid_nxt = b_valid_r;
    b_cx_nxt    = b_cx_r;
    b_cy_nxt    = b_cy_r;
    b_cz_nxt    = b_cz_r;
    b_rad_nxt   = b_rad_r;
    b_tag_nxt   = b_tag_r;
    if (b_ready) begin
      b_valid_nxt    = a_valid_r;
      b_cx_nxt       = a_cx_r;
      b_cy_nxt       = a_cy_r;
      b_cz_nxt       = a_cz_r;
      b_rad_nxt      = a_rad_r;
      b_tag_nxt.last = a_tag_r.last;
      b_tag_nxt.vis  = a_tag_r.vis && !dist_sum[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r   <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      plane_r   <= plane_nxt;
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_px_r  <= a_px_nxt;
    a_py_r  <= a_py_nxt;
    a_pz_r  <= a_pz_nxt;
    a_cx_r  <= a_cx_nxt;
    a_cy_r  <= a_cy_nxt;
    a_cz_r  <= a_cz_nxt;
    a_rad_r <= a_rad_nxt;
    a_tag_r <= a_tag_nxt;
    b_cx_r  <= b_cx_nxt;
    b_cy_r  <= b_cy_nxt;
    b_cz_r  <= b_cz_nxt;
    b_rad_r <= b_rad_nxt;
    b_tag_r <= b_tag_nxt;
  end

  assign dn_valid = b_valid_r;
  assign dn_cx    = b_cx_r;
  assign dn_cy    = b_cy_r;
  assign dn_cz    = b_cz_r;
  assign dn_rad   = b_rad_r;
  assign dn_tag   = b_tag_r;

`ifndef NO_ASSERTIONS
  // A word in the product stage must not be lost while the compare stage stalls.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_ready) |=> (a_valid_r && $stable(a_px_r) && $stable(a_tag_r)))
    else $error("product stage changed while stalled");

  // A sphere culled by an earlier plane stays culled.
  vis_never_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (b_ready && a_valid_r && !a_tag_r.vis) |=> !b_tag_r.vis)
    else $error("visibility restored after cull");

  // An all-zero plane never culls.
  zero_plane_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (plane_r == '0 && b_ready && a_valid_r) |=> (b_tag_r.vis == $past(a_tag_r.vis)))
    else $error("zero plane culled a sphere");

  // The batch end flag moves with its word.
  last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (b_ready && a_valid_r) |=> (b_valid_r && b_tag_r.last == $past(a_tag_r.last)))
    else $error("last flag lost between stages");
`endif

endmodule

### design/frustum_sphere_cull_core.sv
// Frustum sphere cull top level: a chain of NUM_PLANES plane cells.
// Depends on fsc_pkg and fsc_cell.
//
// Accepts one sphere per clock and returns one visibility word per sphere, in
// order, with the batch end flag copied through. Each plane cell is two
// register stages deep (multiply, then sum and compare); the throughput of one
// word per cycle holds whenever the output side takes words. Ready passes back
// through the chain combinationally, so a stall reaches back across all full
// stages in the same cycle, empty stages absorb words, and no word is dropped.
// The user must write plane registers through the cfg port only while the
// chain is empty; the block itself does not enforce this. Indexes six and up
// are ignored, and planes without a register stay zero and never cull. All
// arithmetic is exact.
module frustum_sphere_cull_core #(
  parameter int NUM_PLANES  = fsc_pkg::NUM_PLANES_DEF,
  parameter int COORD_WIDTH = fsc_pkg::COORD_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_x,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_y,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_z,
  input  logic [fsc_pkg::RADIUS_W-1:0]       in_sphere_radius,
  input  logic                               in_last_sphere,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_visible,
  output logic                               out_last_result
);
  import fsc_pkg::*;

  logic                          ch_valid [NUM_PLANES+1];
  logic                          ch_ready [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] ch_cx    [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] ch_cy    [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] ch_cz    [NUM_PLANES+1];
  logic [RADIUS_W-1:0]           ch_rad   [NUM_PLANES+1];
  cull_tag_t                     ch_tag   [NUM_PLANES+1];
  logic [NUM_PLANES-1:0]         plane_we;

  assign ch_valid[0]    = in_valid;
  assign in_ready       = ch_ready[0];
  assign ch_cx[0]       = COORD_WIDTH'(in_center_x);
  assign ch_cy[0]       = COORD_WIDTH'(in_center_y);
  assign ch_cz[0]       = COORD_WIDTH'(in_center_z);
  assign ch_rad[0]      = in_sphere_radius;
  assign ch_tag[0].last = in_last_sphere;
  assign ch_tag[0].vis  = 1'b1;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    assign plane_we[p] = cfg_we && (cfg_index == CFG_INDEX_W'(p)) && (p < PLANE_REGS);

    fsc_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .plane_we    (plane_we[p]),
      .plane_wdata (cfg_wdata),
      .up_valid    (ch_valid[p]),
      .up_ready    (ch_ready[p]),
      .up_cx       (ch_cx[p]),
      .up_cy       (ch_cy[p]),
      .up_cz       (ch_cz[p]),
      .up_rad      (ch_rad[p]),
      .up_tag      (ch_tag[p]),
      .dn_valid    (ch_valid[p+1]),
      .dn_ready    (ch_ready[p+1]),
      .dn_cx       (ch_cx[p+1]),
      .dn_cy       (ch_cy[p+1]),
      .dn_cz       (ch_cz[p+1]),
      .dn_rad      (ch_rad[p+1]),
      .dn_tag      (ch_tag[p+1])
    );
  end

  assign ch_ready[NUM_PLANES] = out_ready;
  assign out_valid            = ch_valid[NUM_PLANES];
  assign out_visible          = ch_tag[NUM_PLANES].vis;
  assign out_last_result      = ch_tag[NUM_PLANES].last;

`ifndef NO_ASSERTIONS
  // Writes to indexes without a plane register must not reach any cell.
  no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index >= CFG_INDEX_W'(PLANE_REGS)) |-> (plane_we == '0))
    else $error("write to unarchitected plane index");

  // At most one cell takes a configuration write.
  one_plane_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(plane_we))
    else $error("several planes written at once");

  // With the output side open the chain never blocks the input.
  chain_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready && $past(out_ready)) |-> in_ready)
    else $error("input blocked while output drains");
`endif

endmodule

### tb/sphere_cull_checker.sv
`timescale 1ns / 100ps
// Scoreboard for frustum_sphere_cull_core: mirrors the plane registers from the cfg port,
// predicts the verdict of every accepted sphere and compares each result word in order.
// Depends on fsc_pkg.
module sphere_cull_checker #(
  parameter int NUM_PLANES = fsc_pkg::NUM_PLANES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_x,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_y,
  input  logic signed [fsc_pkg::FIELD_W-1:0] in_center_z,
  input  logic [fsc_pkg::RADIUS_W-1:0]       in_sphere_radius,
  input  logic                               in_last_sphere,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_visible,
  input  logic                               out_last_result,
  output int                                 err_count,
  output int                                 pending,
  output int                                 n_checked,
  output int                                 n_culled
);

  typedef struct packed {
    logic visible;
    logic last;
  } verdict_t;

  verdict_t                       expected_verdicts[$];
  logic [fsc_pkg::CFG_DATA_W-1:0] plane_copy[NUM_PLANES];
  int                             failures = 0;
  int                             checked  = 0;
  int                             culled   = 0;

  // Exact signed distance per plane in 22 fraction bits; a 64-bit sum cannot overflow.
  function automatic logic sphere_in_frustum(logic signed [15:0] cx, logic signed [15:0] cy,
                                             logic signed [15:0] cz, logic [14:0] radius);
    longint                         reach;
    longint                         plane_dist;
    logic [fsc_pkg::CFG_DATA_W-1:0] pw;
    logic                           vis;
    vis   = 1'b1;
    reach = longint'(radius) <<< fsc_pkg::FRAC_ALIGN;
    for (int p = 0; p < NUM_PLANES; p++) begin
      pw         = plane_copy[p];
      plane_dist = longint'(signed'(pw[fsc_pkg::NX_LSB +: 16])) * longint'(cx)
                 + longint'(signed'(pw[fsc_pkg::NY_LSB +: 16])) * longint'(cy)
                 + longint'(signed'(pw[fsc_pkg::NZ_LSB +: 16])) * longint'(cz)
                 + (longint'(signed'(pw[fsc_pkg::D_LSB +: 16])) <<< fsc_pkg::FRAC_ALIGN);
      if (plane_dist < -reach) vis = 1'b0;
    end
    return vis;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      expected_verdicts.delete();
      foreach (plane_copy[p]) plane_copy[p] = '0;
    end else begin
      if (in_valid && in_ready) begin
        want.visible = sphere_in_frustum(in_center_x, in_center_y, in_center_z,
                                         in_sphere_radius);
        want.last    = in_last_sphere;
        expected_verdicts.push_back(want);
      end
      // Writes past the plane file are dropped by the block as well.
      if (cfg_we && cfg_index < fsc_pkg::PLANE_REGS && cfg_index < NUM_PLANES)
        plane_copy[cfg_index] = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("result word visible=%0b last=%0b with nothing expected",
                                 out_visible, out_last_result));
        end else begin
          want = expected_verdicts.pop_front();
          if (!want.visible) culled++;
          if (out_visible !== want.visible)
            note_failure($sformatf("word %0d visible: expected %0b, got %0b",
                                   checked, want.visible, out_visible));
          if (out_last_result !== want.last)
            note_failure($sformatf("word %0d last_result: expected %0b, got %0b",
                                   checked, want.last, out_last_result));
          checked++;
        end
      end
    end
    err_count <= failures;
    pending   <= expected_verdicts.size();
    n_checked <= checked;
    n_culled  <= culled;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the frustum_sphere_cull_core testbench: clock, reset, plane programming and sphere
// stimulus with random gaps and output stalls. Depends on fsc_pkg, the core, sphere_cull_checker.
module tb;

  localparam int NUM_PLANES  = fsc_pkg::NUM_PLANES_DEF;
  localparam int LATENCY     = 2 * NUM_PLANES;
  localparam int CYCLE_LIMIT = 300000;

  localparam int PLANE_LEFT   = 0;
  localparam int PLANE_RIGHT  = 1;
  localparam int PLANE_BOTTOM = 2;
  localparam int PLANE_TOP    = 3;
  localparam int PLANE_NEAR   = 4;
  localparam int PLANE_FAR    = 5;

  localparam logic [15:0] ONE_Q14       = 16'h4000;
  localparam logic [15:0] MINUS_ONE_Q14 = 16'hC000;
  localparam logic [15:0] TEN_Q88       = 16'h0A00;
  localparam logic [15:0] MOST_NEG      = 16'h8000;
  localparam logic [15:0] MOST_POS      = 16'h7FFF;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [14:0] radius;
    logic        last;
  } sphere_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [fsc_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [fsc_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [fsc_pkg::FIELD_W-1:0] in_center_x;
  logic signed [fsc_pkg::FIELD_W-1:0] in_center_y;
  logic signed [fsc_pkg::FIELD_W-1:0] in_center_z;
  logic [fsc_pkg::RADIUS_W-1:0]       in_sphere_radius;
  logic                               in_last_sphere;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               out_visible;
  logic                               out_last_result;

  int err_count;
  int pending;
  int n_checked;
  int n_culled;

  logic [fsc_pkg::CFG_DATA_W-1:0] plane_set[fsc_pkg::PLANE_REGS];
  int n_sent         = 0;
  int n_settings     = 0;
  int in_gap_mode    = 0;
  int out_stall_mode = 0;
  int stall_left     = 0;
  int cycle_count    = 0;

  frustum_sphere_cull_core #(.NUM_PLANES(NUM_PLANES)) dut (.*);

  sphere_cull_checker #(.NUM_PLANES(NUM_PLANES)) u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output stalls: mode 0 never stalls, 1 stalls briefly, 2 adds the odd long stall.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_stall_mode != 0 && $urandom_range(0, 99) < 30) begin
      stall_left = (out_stall_mode == 2 && $urandom_range(0, 9) == 0) ?
                   $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frustum_sphere_cull_core regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                             logic [15:0] nz, logic [15:0] d);
    return {d, nz, ny, nx};
  endfunction

  function automatic sphere_t mk_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                        logic [14:0] radius, logic last);
    sphere_t s;
    s.cx     = cx;
    s.cy     = cy;
    s.cz     = cz;
    s.radius = radius;
    s.last   = last;
    return s;
  endfunction

  // A span of zero draws every field over its full range.
  function automatic sphere_t rand_sphere(int span, int rmax);
    sphere_t s;
    if (span == 0) begin
      s.cx     = 16'($urandom);
      s.cy     = 16'($urandom);
      s.cz     = 16'($urandom);
      s.radius = 15'($urandom);
    end else begin
      s.cx     = 16'(int'($urandom_range(0, 2 * span)) - span);
      s.cy     = 16'(int'($urandom_range(0, 2 * span)) - span);
      s.cz     = 16'(int'($urandom_range(0, 2 * span)) - span);
      s.radius = 15'($urandom_range(0, rmax));
    end
    s.last = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  function automatic int pick_gap(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0 || roll < 60) return 0;
    if (mode == 1 || roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_sphere(sphere_t s);
    int gap;
    if (n_sent % 40 == 0) begin
      in_gap_mode = $urandom_range(0, 2);
      out_stall_mode <= $urandom_range(0, 2);
    end
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_center_x      <= s.cx;
    in_center_y      <= s.cy;
    in_center_z      <= s.cz;
    in_sphere_radius <= s.radius;
    in_last_sphere   <= s.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_random(int count, int span, int rmax, int full_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < full_pct) send_sphere(rand_sphere(0, 0));
      else send_sphere(rand_sphere(span, rmax));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes the six planes, then junk to the indexes past them, which must be dropped.
  task automatic load_planes();
    for (int i = 0; i < fsc_pkg::PLANE_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= fsc_pkg::CFG_INDEX_W'(i);
      cfg_wdata <= plane_set[i];
      @(posedge clk);
    end
    for (int i = fsc_pkg::PLANE_REGS; i < 2 ** fsc_pkg::CFG_INDEX_W; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= fsc_pkg::CFG_INDEX_W'(i);
      cfg_wdata <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_center_x      = '0;
    in_center_y      = '0;
    in_center_z      = '0;
    in_sphere_radius = '0;
    in_last_sphere   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Planes straight out of reset are all zero, so nothing may be culled.
    send_sphere(mk_sphere(MOST_NEG, MOST_NEG, MOST_NEG, 15'h0000, 1'b0));
    send_sphere(mk_sphere(MOST_POS, MOST_POS, MOST_POS, 15'h7FFF, 1'b1));
    send_sphere(mk_sphere(MOST_NEG, MOST_POS, 16'h0000, 15'h7FFF, 1'b0));
    send_sphere(mk_sphere(16'hFFFF, 16'h0001, MOST_NEG, 15'h0001, 1'b1));
    send_sphere(mk_sphere(16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA, 1'b0));
    send_sphere(mk_sphere(16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555, 1'b1));
    send_random(50, 0, 0, 100);
    wait_drained();

    // Axis-aligned box of half-width 10 on every axis.
    plane_set[PLANE_LEFT]   = pack_plane(ONE_Q14, 16'h0000, 16'h0000, TEN_Q88);
    plane_set[PLANE_RIGHT]  = pack_plane(MINUS_ONE_Q14, 16'h0000, 16'h0000, TEN_Q88);
    plane_set[PLANE_BOTTOM] = pack_plane(16'h0000, ONE_Q14, 16'h0000, TEN_Q88);
    plane_set[PLANE_TOP]    = pack_plane(16'h0000, MINUS_ONE_Q14, 16'h0000, TEN_Q88);
    plane_set[PLANE_NEAR]   = pack_plane(16'h0000, 16'h0000, ONE_Q14, TEN_Q88);
    plane_set[PLANE_FAR]    = pack_plane(16'h0000, 16'h0000, MINUS_ONE_Q14, TEN_Q88);
    load_planes();
    // Centre, touching, one step outside, and spheres outside whose radius reaches back.
    send_sphere(mk_sphere(16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0));
    send_sphere(mk_sphere(-16'sd2560, 16'h0000, 16'h0000, 15'h0000, 1'b0));
    send_sphere(mk_sphere(-16'sd2561, 16'h0000, 16'h0000, 15'h0000, 1'b0));
    send_sphere(mk_sphere(-16'sd2561, 16'h0000, 16'h0000, 15'h0001, 1'b0));
    send_sphere(mk_sphere(16'h0000, 16'h0000, 16'sd2817, 15'd257, 1'b1));
    send_random(200, 6144, 2048, 20);
    wait_drained();

    // Tilted planes with normals within one and moderate offsets.
    foreach (plane_set[i])
      plane_set[i] = pack_plane(16'(int'($urandom_range(0, 32768)) - 16384),
                                16'(int'($urandom_range(0, 32768)) - 16384),
                                16'(int'($urandom_range(0, 32768)) - 16384),
                                16'(int'($urandom_range(0, 8192)) - 4096));
    load_planes();
    send_random(120, 4096, 1024, 10);
    wait_drained();

    // Planes at the ends of their ranges, unnormalized as software could leave them.
    plane_set[PLANE_LEFT]   = pack_plane(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    plane_set[PLANE_RIGHT]  = pack_plane(MOST_POS, MOST_POS, MOST_POS, MOST_POS);
    plane_set[PLANE_BOTTOM] = pack_plane(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
    plane_set[PLANE_TOP]    = pack_plane(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG);
    plane_set[PLANE_NEAR]   = pack_plane(MOST_NEG, 16'h0000, MOST_POS, MOST_POS);
    plane_set[PLANE_FAR]    = pack_plane(MOST_POS, MOST_POS, MOST_NEG, MOST_NEG);
    load_planes();
    send_sphere(mk_sphere(MOST_NEG, MOST_NEG, MOST_NEG, 15'h7FFF, 1'b0));
    send_sphere(mk_sphere(MOST_POS, MOST_POS, MOST_POS, 15'h7FFF, 1'b0));
    send_sphere(mk_sphere(MOST_NEG, MOST_NEG, MOST_NEG, 15'h0000, 1'b1));
    send_sphere(mk_sphere(MOST_POS, MOST_POS, MOST_POS, 15'h0000, 1'b0));
    send_sphere(mk_sphere(16'h0000, 16'h0000, 16'h0000, 15'h0000, 1'b0));
    send_sphere(mk_sphere(MOST_POS, MOST_NEG, MOST_POS, 15'h4000, 1'b1));
    send_random(60, 0, 0, 100);
    wait_drained();

    foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
    load_planes();
    send_random(70, 512, 4096, 85);
    wait_drained();

    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d spheres over %0d plane settings plus the reset planes.",
             n_sent, n_settings);
    $display("Checked %0d result words, %0d of them culled, with gaps and stalls on both sides.",
             n_checked, n_culled);
    if (err_count == 0) begin
      $display("frustum_sphere_cull_core regression: pass");
    end else begin
      $display("frustum_sphere_cull_core regression: fail");
    end
    $finish;
  end

endmodule
